FILE: hdl/sle_pkg.sv
// sle_pkg: shared constants and types for the sequential list engine.
// No dependencies; imported by sle_cell, sequential_list_engine and tb.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int DATA_W           = 32;
  localparam int FUNC_W           = 3;
  localparam int POS_W            = 7;

  // command codes carried on in_tuser
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LOCATE = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_PURGE  = 3'd5;

  // what every cell does this cycle
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_ROTATE,
    CM_INSERT,
    CM_SHIFT_DOWN,
    CM_COMPACT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       phase;      // odd/even pairing for compaction
    logic       tail_kill;  // drop mark for the entry wrapping to the tail
  } cell_ctrl_t;

endpackage

FILE: hdl/sle_cell.sv
// sle_cell: one list entry with its drop mark, talking to both neighbours.
// Depends on sle_pkg.
`timescale 1ns / 1ps

module sle_cell
  import sle_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CW    = 7
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CW-1:0]     cnt_i,
  input  logic [CW-1:0]     pos0_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] head_data_i,
  input  logic [DATA_W-1:0] left_data_i,
  input  logic              left_dead_i,
  input  logic [DATA_W-1:0] right_data_i,
  input  logic              right_dead_i,
  output logic [DATA_W-1:0] data_o,
  output logic              dead_o
);

  localparam logic [CW-1:0] IDX      = CW'(INDEX);
  localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);
  localparam logic          IS_ODD   = 1'(INDEX % 2);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              kill_r, kill_nxt;
  logic              in_list, is_tail, pair_left;

  assign in_list   = IDX < cnt_i;
  assign is_tail   = IDX_NEXT == cnt_i;
  assign pair_left = IS_ODD == ctrl_i.phase;
  assign dead_o    = kill_r || !in_list;
  assign data_o    = data_r;

  always_comb begin
    data_nxt = data_r;
    kill_nxt = kill_r;
    case (ctrl_i.mode)
      CM_ROTATE: begin
        if (in_list) begin
          if (is_tail) begin
            data_nxt = head_data_i;
            kill_nxt = ctrl_i.tail_kill;
          end else begin
            data_nxt = right_data_i;
            kill_nxt = right_dead_i;
          end
        end
      end
      CM_INSERT: begin
        if (IDX > pos0_i) begin
          data_nxt = left_data_i;
        end else if (IDX == pos0_i) begin
          data_nxt = value_i;
        end
      end
      CM_SHIFT_DOWN: begin
        if (IDX >= pos0_i) begin
          data_nxt = right_data_i;
        end
      end
      CM_COMPACT: begin
        // live entries only ever pass dropped ones, so order is kept
        if (pair_left) begin
          if (dead_o && !right_dead_i) begin
            data_nxt = right_data_i;
            kill_nxt = 1'b0;
          end
        end else if (!dead_o && left_dead_i) begin
          data_nxt = left_data_i;
          kill_nxt = 1'b1;
        end
      end
      default: begin
        data_nxt = data_r;
        kill_nxt = kill_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    kill_r <= kill_nxt;
  end

endmodule

FILE: hdl/sequential_list_engine.sv
// sequential_list_engine: ordered list of signed 32-bit values in a row of cells.
// Depends on sle_pkg and sle_cell.
`timescale 1ns / 1ps
//
// Channel | Direction | Ports                              | Item
// --------+-----------+------------------------------------+---------------------------
// in_     | slave     | in_tvalid/in_tready/in_tdata/tuser | command: func, position,
//         |           |                                    | value
// out_    | master    | out_tvalid/out_tready/out_tdata    | result: ok, item_value,
//         |           |                                    | found_position, list_size
//
// One command at a time. Clear, insert and bad commands need no turn of the cell
// ring; read, locate, delete and remove-all-equal rotate the whole list once past
// cell 0, delete then shifts the later entries down, and remove-all-equal adds n
// odd/even compaction rounds across the row, with n entries in the list.
// rst_n (synchronous, active low) empties the list; entry storage is not cleared.
// A new command is taken as soon as the engine is idle, even while the
// previous result waits in the output register for out_tready.

module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  logic [2:0]  in_tuser,   // [2:0] func
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [0] ok, [32:1] item_value,
                                  // [39:33] found_position, [46:40] list_size
);

  localparam int CW = $clog2(CAPACITY + 1);    // holds 0..CAPACITY
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_COMPACT,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       k_r, k_nxt;          // scan step / compaction round
  logic [CW-1:0]       kept_r, kept_nxt;
  logic [CW-1:0]       found_r, found_nxt;
  logic                ok_r, ok_nxt;
  logic [DATA_W-1:0]   item_r, item_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [47:0]         out_data_r, out_data_nxt;

  cell_ctrl_t          ctrl;
  logic [PW-1:0]       pos_w, cnt_w, found_w, size_w;
  logic [CW-1:0]       pos0;
  logic                pos_in_list, pos_insertable, head_match, scan_last, out_free;

  logic [DATA_W-1:0]   cell_data [CAPACITY];
  logic                cell_dead [CAPACITY];

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [DATA_W-1:0] left_data, right_data;
    logic              left_dead, right_dead;
    if (gi == 0) begin : g_first
      assign left_data = '0;
      assign left_dead = 1'b0;      // nothing to pull from the left end
    end else begin : g_mid_l
      assign left_data = cell_data[gi-1];
      assign left_dead = cell_dead[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[gi];
      assign right_dead = 1'b1;     // nothing live beyond the right end
    end else begin : g_mid_r
      assign right_data = cell_data[gi+1];
      assign right_dead = cell_dead[gi+1];
    end
    sle_cell #(
      .INDEX (gi),
      .CW    (CW)
    ) u_cell (
      .clk          (clk),
      .ctrl_i       (ctrl),
      .cnt_i        (cnt_r),
      .pos0_i       (pos0),
      .value_i      (val_r),
      .head_data_i  (cell_data[0]),
      .left_data_i  (left_data),
      .left_dead_i  (left_dead),
      .right_data_i (right_data),
      .right_dead_i (right_dead),
      .data_o       (cell_data[gi]),
      .dead_o       (cell_dead[gi])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign pos_w          = PW'(pos_r);
  assign cnt_w          = PW'(cnt_r);
  assign pos0           = CW'(pos_w - PW'(1));
  assign pos_in_list    = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_insertable = (pos_w != '0) && (pos_w <= cnt_w + PW'(1))
                          && (cnt_r < CW'(CAPACITY));
  assign head_match     = cell_data[0] == val_r;
  assign scan_last      = (k_r + CW'(1)) == cnt_r;
  assign out_free       = !out_valid_r || out_tready;
  assign found_w        = PW'(found_r);
  assign size_w         = PW'(cnt_r);

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    kept_nxt      = kept_r;
    found_nxt     = found_r;
    ok_nxt        = ok_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctrl          = '{mode: CM_HOLD, phase: 1'b0, tail_kill: 1'b0};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_tuser;
          pos_nxt   = in_tdata[POS_W-1:0];
          val_nxt   = in_tdata[POS_W+DATA_W-1:POS_W];
          state_nxt = S_START;
        end
      end
      S_START: begin
        ok_nxt    = 1'b0;
        item_nxt  = '0;
        found_nxt = '0;
        kept_nxt  = '0;
        k_nxt     = '0;
        state_nxt = S_DONE;
        case (func_r)
          FUNC_CLEAR: begin
            cnt_nxt = '0;
            ok_nxt  = 1'b1;
          end
          FUNC_INSERT: begin
            if (pos_insertable) begin
              ctrl.mode = CM_INSERT;
              cnt_nxt   = cnt_r + CW'(1);
              ok_nxt    = 1'b1;
            end
          end
          FUNC_DELETE, FUNC_READ: begin
            if (pos_in_list) begin
              ok_nxt    = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          FUNC_LOCATE, FUNC_PURGE: begin
            ok_nxt = 1'b1;
            if (cnt_r != '0) begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end
      S_SCAN: begin
        // cell 0 holds entry k_r; one full turn puts every entry back
        ctrl.mode      = CM_ROTATE;
        ctrl.tail_kill = head_match;
        k_nxt          = k_r + CW'(1);
        if (k_r == pos0) begin
          item_nxt = cell_data[0];
        end
        if (head_match && (found_r == '0)) begin
          found_nxt = k_r + CW'(1);
        end
        if (!head_match) begin
          kept_nxt = kept_r + CW'(1);
        end
        if (scan_last) begin
          k_nxt = '0;
          case (func_r)
            FUNC_DELETE: state_nxt = S_SHIFT;
            FUNC_PURGE:  state_nxt = S_COMPACT;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_SHIFT: begin
        ctrl.mode = CM_SHIFT_DOWN;
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_DONE;
      end
      S_COMPACT: begin
        // odd/even transposition: n rounds settle n entries
        ctrl.mode  = CM_COMPACT;
        ctrl.phase = k_r[0];
        k_nxt      = k_r + CW'(1);
        if (scan_last) begin
          cnt_nxt   = kept_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, size_w[POS_W-1:0],
                           (func_r == FUNC_LOCATE) ? found_w[POS_W-1:0] : {POS_W{1'b0}},
                           (func_r == FUNC_DELETE || func_r == FUNC_READ) ? item_r
                                                                          : {DATA_W{1'b0}},
                           ok_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    k_r        <= k_nxt;
    kept_r     <= kept_nxt;
    found_r    <= found_nxt;
    ok_r       <= ok_nxt;
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken while another is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> k_r < cnt_r)
    else $error("scan step outside the list");

  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_tvalid && state_r == S_IDLE)
    else $error("finished command did not reach the output register");
`endif

endmodule

FILE: tb/tb.sv
// tb: self-checking bench for sequential_list_engine. Commands are checked against
// a shadow copy of the list. Depends on sle_pkg and the sequential_list_engine RTL.
`timescale 1ns / 1ps

module tb;
  import sle_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_LEN = 160;

  // codes the engine must ignore
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } list_cmd_t;

  // packed to match out_tdata[46:0], ok in bit 0
  typedef struct packed {
    logic [POS_W-1:0]  list_size;
    logic [POS_W-1:0]  found_position;
    logic [DATA_W-1:0] item_value;
    logic              ok;
  } list_res_t;

  typedef struct packed {
    list_cmd_t cmd;
    list_res_t res;
  } pending_cmd_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} cmd_mix_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata = '0;
  logic [2:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;

  // shadow of the list, advanced as commands are queued
  logic [DATA_W-1:0] shadow_entries [CAP];
  int                shadow_len = 0;

  pending_cmd_t      pending_cmds [$];
  list_res_t         expected_results [$];
  list_res_t         offered_res = '0;
  int                send_gap = 0;
  int                recv_gap = 0;
  int                cmds_taken = 0;
  int                errors = 0;
  logic              quiet = 1'b0;
  logic [7:0]        quiet_cnt = '0;
  logic              choke = 1'b0;

  logic [DATA_W-1:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                        32'h8000_0000, 32'h7FFF_FFFF, 32'h55AA_55AA,
                                        32'h0000_0005, 32'hA5A5_0006};

  sequential_list_engine #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one command to the shadow list and return the result it should give.
  function automatic list_res_t apply_list_cmd(list_cmd_t c);
    list_res_t res;
    int        pos;
    int        j;
    int        k;
    res = '0;
    pos = c.position;
    case (c.func)
      FUNC_CLEAR: begin
        shadow_len = 0;
        res.ok = 1'b1;
      end
      FUNC_INSERT: begin
        if (shadow_len < CAP && pos >= 1 && pos <= shadow_len + 1) begin
          for (j = shadow_len; j > pos - 1; j--) shadow_entries[j] = shadow_entries[j-1];
          shadow_entries[pos-1] = c.value;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (pos >= 1 && pos <= shadow_len) begin
          res.item_value = shadow_entries[pos-1];
          for (j = pos - 1; j + 1 < shadow_len; j++) shadow_entries[j] = shadow_entries[j+1];
          shadow_len--;
          res.ok = 1'b1;
        end
      end
      FUNC_READ: begin
        if (pos >= 1 && pos <= shadow_len) begin
          res.item_value = shadow_entries[pos-1];
          res.ok = 1'b1;
        end
      end
      FUNC_LOCATE: begin
        for (j = shadow_len - 1; j >= 0; j--)
          if (shadow_entries[j] == c.value) res.found_position = POS_W'(j + 1);
        res.ok = 1'b1;
      end
      FUNC_PURGE: begin
        k = 0;
        for (j = 0; j < shadow_len; j++) begin
          if (shadow_entries[j] != c.value) begin
            shadow_entries[k] = shadow_entries[j];
            k++;
          end
        end
        shadow_len = k;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.list_size = POS_W'(shadow_len);
    return res;
  endfunction

  task automatic queue_cmd(logic [FUNC_W-1:0] func, int pos, logic [DATA_W-1:0] value);
    pending_cmd_t p;
    p.cmd.func     = func;
    p.cmd.position = POS_W'(pos);
    p.cmd.value    = value;
    p.res          = apply_list_cmd(p.cmd);
    pending_cmds.push_back(p);
  endtask

  // mostly no gap, some short, a few long; none at all in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 64);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(cmd_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) != 0) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
    case (mix)
      MIX_FILL: begin
        if (r < 68) return FUNC_INSERT;
        if (r < 76) return FUNC_DELETE;
        if (r < 87) return FUNC_READ;
        if (r < 96) return FUNC_LOCATE;
        return FUNC_PURGE;
      end
      MIX_DRAIN: begin
        if (r < 22) return FUNC_INSERT;
        if (r < 58) return FUNC_DELETE;
        if (r < 72) return FUNC_READ;
        if (r < 84) return FUNC_LOCATE;
        if (r < 98) return FUNC_PURGE;
        return FUNC_CLEAR;
      end
      default: begin
        if (r < 38) return FUNC_INSERT;
        if (r < 62) return FUNC_DELETE;
        if (r < 77) return FUNC_READ;
        if (r < 89) return FUNC_LOCATE;
        if (r < 98) return FUNC_PURGE;
        return FUNC_CLEAR;
      end
    endcase
  endfunction

  // position for a noisy command: zero, one past the end, or anything the field holds
  function automatic int bad_position(int first_bad);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return (first_bad > 127) ? 127 : first_bad;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(bit from_list);
    int r;
    r = $urandom_range(0, 99);
    if (from_list && shadow_len > 0 && r < 60)
      return shadow_entries[$urandom_range(0, shadow_len - 1)];
    if (r < 80) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic build_random_cmds();
    cmd_mix_t          mix;
    logic [FUNC_W-1:0] func;
    bit                noisy;
    int                i;
    int                pos;
    mix = MIX_FILL;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // first phase mostly inserts to fill the list, later ones are drawn at random
      if (i > 0 && i % PHASE_LEN == 0) mix = cmd_mix_t'($urandom_range(0, 2));
      func  = pick_func(mix);
      noisy = ($urandom_range(0, 99) < 12);
      case (func)
        FUNC_INSERT: begin
          pos = noisy ? bad_position(shadow_len + 2) : $urandom_range(1, shadow_len + 1);
          queue_cmd(func, pos, ($urandom_range(0, 1) != 0) ? pick_value(0) : $urandom);
        end
        FUNC_DELETE, FUNC_READ: begin
          pos = (noisy || shadow_len == 0) ? bad_position(shadow_len + 1)
                                            : $urandom_range(1, shadow_len);
          queue_cmd(func, pos, $urandom);
        end
        FUNC_LOCATE, FUNC_PURGE:
          queue_cmd(func, $urandom_range(0, 127), pick_value(1));
        default:
          queue_cmd(func, $urandom_range(0, 127), $urandom);
      endcase
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    pending_cmd_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(offered_res);
        cmds_taken <= cmds_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds.pop_front();
          in_tdata    <= {1'b0, nxt.cmd.value, nxt.cmd.position};
          in_tuser    <= nxt.cmd.func;
          in_tvalid   <= 1'b1;
          offered_res <= nxt.res;
          send_gap    <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk) begin
    list_res_t got;
    list_res_t want;
    int        g;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = list_res_t'(out_tdata[46:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result ok=%0b item=%h found=%0d size=%0d", $time,
                   got.ok, got.item_value, got.found_position, got.list_size);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok || got.item_value !== want.item_value ||
              got.found_position !== want.found_position ||
              got.list_size !== want.list_size) begin
            $display("%0t: mismatch expected ok=%0b item=%h found=%0d size=%0d",
                     $time, want.ok, want.item_value, want.found_position, want.list_size);
            $display("%0t:          actual   ok=%0b item=%h found=%0d size=%0d",
                     $time, got.ok, got.item_value, got.found_position, got.list_size);
            errors++;
          end
        end
      end
      if (choke) begin
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        g = pick_gap();
        recv_gap   <= g;
        out_tready <= (g == 0);
      end else if (recv_gap > 0) begin
        recv_gap   <= recv_gap - 1;
        out_tready <= (recv_gap == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // stretches with no idling on either side
  always @(posedge clk) begin
    quiet_cnt <= quiet_cnt + 8'd1;
    if (quiet_cnt == 8'd0) quiet <= ($urandom_range(0, 3) == 0);
  end

  // receiver holds off for a long stretch so the engine backs up onto its input
  initial begin
    int t;
    for (t = 300; t <= 1100; t += 800) begin
      while (cmds_taken < t) @(posedge clk);
      choke <= 1'b1;
      repeat (400) @(posedge clk);
      choke <= 1'b0;
    end
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------- stimulus
  initial begin
    // empty list: reads, deletes and inserts past the end all fail
    queue_cmd(FUNC_READ,    1,   32'h0000_0000);
    queue_cmd(FUNC_INSERT,  0,   32'h1111_1111);
    queue_cmd(FUNC_INSERT,  2,   32'h2222_2222);
    queue_cmd(FUNC_DELETE,  1,   32'h0000_0000);
    queue_cmd(FUNC_LOCATE,  0,   32'h0000_0000);
    queue_cmd(FUNC_PURGE,   0,   32'h0000_0000);
    // build up at head, tail and middle with extreme values
    queue_cmd(FUNC_INSERT,  1,   32'h7FFF_FFFF);
    queue_cmd(FUNC_INSERT,  1,   32'h8000_0000);
    queue_cmd(FUNC_INSERT,  3,   32'hFFFF_FFFF);
    queue_cmd(FUNC_INSERT,  2,   32'h0000_0000);
    queue_cmd(FUNC_INSERT,  127, 32'hFFFF_FFFF);
    queue_cmd(FUNC_READ,    4,   32'h0000_0000);
    queue_cmd(FUNC_READ,    5,   32'h0000_0000);
    queue_cmd(FUNC_LOCATE,  0,   32'h8000_0000);
    queue_cmd(FUNC_LOCATE,  0,   32'h1234_5678);
    // duplicate then remove every copy
    queue_cmd(FUNC_INSERT,  5,   32'h7FFF_FFFF);
    queue_cmd(FUNC_LOCATE,  0,   32'h7FFF_FFFF);
    queue_cmd(FUNC_PURGE,   0,   32'h7FFF_FFFF);
    queue_cmd(FUNC_DELETE,  1,   32'h0000_0000);
    queue_cmd(FUNC_DELETE,  0,   32'h0000_0000);
    queue_cmd(FUNC_DELETE,  3,   32'h0000_0000);
    // ignored codes with every other bit set
    queue_cmd(FUNC_SPARE_LO, 127, 32'hFFFF_FFFF);
    queue_cmd(FUNC_SPARE_HI, 127, 32'hFFFF_FFFF);
    queue_cmd(FUNC_CLEAR,   127, 32'hFFFF_FFFF);
    queue_cmd(FUNC_READ,    1,   32'h0000_0000);
    build_random_cmds();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    // longest command is a purge over a full list
    repeat (2 * CAP + 16) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sequential_list_engine.f
hdl/sle_pkg.sv
hdl/sle_cell.sv
hdl/sequential_list_engine.sv
tb/tb.sv
